// ----- hw/rtl/lclp_pkg.sv -----
// Types, codes and constants shared by the line-commanded position loop.
`default_nettype none

package lclp_pkg;

	localparam int unsigned SIG_DIGITS  = 40;
	localparam int unsigned FRAC_DIGITS = 46;
	localparam int unsigned EXP_CAP     = 100000;
	localparam int unsigned P_W         = 19;
	localparam int unsigned FQ_DEPTH    = 4;
	localparam int unsigned OQ_DEPTH    = 4;
	localparam int unsigned STOP_LEN    = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_P     = 8'h50;

	localparam logic [15:0] Q_ONE = 16'd32768;

	localparam logic [2:0] REG_KP      = 3'd0;
	localparam logic [2:0] REG_ILIM    = 3'd1;
	localparam logic [2:0] REG_TRAVEL  = 3'd2;
	localparam logic [2:0] REG_FBTICKS = 3'd3;
	localparam logic [2:0] REG_DLIM    = 3'd4;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic KIND_DRIVE    = 1'b0;
	localparam logic KIND_FEEDBACK = 1'b1;

	typedef enum logic [1:0] {OP_CHAR, OP_EOL, OP_TICK} op_t;

	typedef struct packed {
		logic              command;
		logic [7:0]        rx_byte;
		logic signed [15:0] position;
		logic [15:0]       current_ma;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  drive_dir;
		logic [7:0]  drive_duty;
		logic        driver_on;
		logic        fault;
		logic [15:0] feedback_pos;
		logic        last;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        rx_byte;
		logic signed [15:0] position;
		logic [15:0]       current_ma;
	} queue_entry_t;

	typedef struct packed {
		logic        stop;
		logic        set;
		logic [15:0] level;
	} line_res_t;

	typedef struct packed {
		logic              active;
		logic signed [15:0] position;
		logic [15:0]       current_ma;
		logic [15:0]       setpoint;
	} tick_req_t;

	typedef struct packed {
		logic        trip;
		logic [1:0]  dir;
		logic [7:0]  duty;
		logic [15:0] fpos;
	} tick_resp_t;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ilim;
		logic [15:0] travel;
		logic [7:0]  fbticks;
		logic [7:0]  dlim;
	} cfg_t;

	typedef enum logic [2:0] {
		P_IDLE, P_RD, P_CH, P_EVAL, P_ALIGN, P_DBL, P_DONE
	} parse_state_t;

	typedef enum logic [3:0] {
		G_WS, G_SGN, G_INT, G_FRAC, G_EXP0, G_EXPS, G_EXPD, G_TRAIL, G_ERR
	} gram_t;

	typedef enum logic [2:0] {
		T_IDLE, T_MUL, T_ERR, T_SCALE, T_SAT, T_DIV, T_DONE
	} tick_state_t;

	typedef enum logic [1:0] {B_IDLE, B_LINE, B_TICK} back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lclp_front.sv -----
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none

module lclp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  lclp_pkg::in_item_t    item,
	input  logic                  deq,
	output logic                  q_valid,
	output lclp_pkg::queue_entry_t q_head
);
	import lclp_pkg::*;

	localparam int unsigned PW = $clog2(FQ_DEPTH);
	localparam int unsigned CW = $clog2(FQ_DEPTH + 1);

	queue_entry_t q_mem [FQ_DEPTH];
	queue_entry_t ent;
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic wr, rd;

	always_comb begin
		ent.rx_byte    = item.rx_byte;
		ent.position   = item.position;
		ent.current_ma = item.current_ma;
		if (item.command) begin
			ent.op = OP_TICK;
		end else if (item.rx_byte == CH_LF || item.rx_byte == CH_CR) begin
			ent.op = OP_EOL;
		end else begin
			ent.op = OP_CHAR;
		end
	end

	assign full    = cnt_q == CW'(FQ_DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_head  = q_mem[rd_ptr_q];
	assign wr      = push && !full;
	assign rd      = deq && q_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lclp_parse.sv -----
// Line store and command line interpreter with a digit-serial decimal to Q1.15 converter.
`default_nettype none

module lclp_parse #(
	parameter int unsigned LINE_CHARS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                op_eol,
	input  logic [7:0]          ch,
	output logic                done,
	output lclp_pkg::line_res_t res
);
	import lclp_pkg::*;

	localparam int unsigned CW = $clog2(LINE_CHARS + 1);
	localparam int unsigned AW = $clog2(LINE_CHARS);
	localparam logic [CW-1:0] FULL_CNT = CW'(LINE_CHARS);
	localparam logic [CW-1:0] STOP_CNT = CW'(STOP_LEN);
	localparam logic [5:0] FL = 6'(FRAC_DIGITS);
	localparam logic signed [P_W-1:0] PF_ZERO = P_W'(0);
	localparam logic signed [P_W-1:0] PF_ONE  = P_W'(1);
	localparam logic signed [P_W-1:0] PF_TWO  = P_W'(2);
	localparam logic signed [P_W-1:0] Z_BIG   = P_W'(6);

	logic [7:0] line_mem [LINE_CHARS];
	logic [7:0] rd_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic disc_q, eol_q;
	parse_state_t st_q, st_d;
	gram_t g_q, g_d;
	logic any_q, started_q, rest_q, neg_q, eneg_q, stop_ok_q;
	logic [3:0] first_q;
	logic [5:0] nsig_q;
	logic signed [P_W-1:0] p_q;
	logic [16:0] ex_q;
	logic [3:0] frac_q [FRAC_DIGITS];
	logic [5:0] aux_q;
	logic [3:0] pass_q;
	logic carry_q;
	logic [15:0] acc_q, level_q;
	logic stop_q, set_q;

	logic c_dig, c_ws, c_sp, c_sign, c_dot, c_e, c_nul, c_stop;
	logic [3:0] dval;
	logic mant_dig, exp_dig, in_frac;
	logic [20:0] ex10;
	logic [16:0] ex_n;
	logic gram_ok;
	logic signed [P_W-1:0] pf, zneg;
	logic ev_stop, ev_zero, ev_one, ev_conv;
	logic [5:0] align_cnt;
	logic [4:0] dv;
	logic cn;
	logic [3:0] nd;
	logic [15:0] acc_fin;
	logic store_ch;

	always_comb begin
		c_dig  = rd_q >= CH_0 && rd_q <= CH_9;
		c_ws   = rd_q == CH_SP || (rd_q >= CH_TAB && rd_q <= CH_CR);
		c_sp   = rd_q == CH_SP || rd_q == CH_TAB;
		c_sign = rd_q == CH_PLUS || rd_q == CH_MINUS;
		c_dot  = rd_q == CH_DOT;
		c_e    = rd_q == CH_UE || rd_q == CH_LE;
		c_nul  = rd_q == CH_NUL;
		dval   = rd_q[3:0];
		case (idx_q[1:0])
			2'd0:    c_stop = rd_q == CH_S;
			2'd1:    c_stop = rd_q == CH_T;
			2'd2:    c_stop = rd_q == CH_O;
			default: c_stop = rd_q == CH_P;
		endcase
	end

	always_comb begin
		unique case (g_q)
			G_WS: begin
				if (c_ws) g_d = G_WS;
				else if (c_sign) g_d = G_SGN;
				else if (c_dig) g_d = G_INT;
				else if (c_dot) g_d = G_FRAC;
				else g_d = G_ERR;
			end
			G_SGN: begin
				if (c_dig) g_d = G_INT;
				else if (c_dot) g_d = G_FRAC;
				else g_d = G_ERR;
			end
			G_INT: begin
				if (c_dig) g_d = G_INT;
				else if (c_dot) g_d = G_FRAC;
				else if (c_e) g_d = G_EXP0;
				else if (c_sp) g_d = G_TRAIL;
				else g_d = G_ERR;
			end
			G_FRAC: begin
				if (c_dig) g_d = G_FRAC;
				else if (c_e && any_q) g_d = G_EXP0;
				else if (c_sp && any_q) g_d = G_TRAIL;
				else g_d = G_ERR;
			end
			G_EXP0: begin
				if (c_sign) g_d = G_EXPS;
				else if (c_dig) g_d = G_EXPD;
				else g_d = G_ERR;
			end
			G_EXPS: begin
				if (c_dig) g_d = G_EXPD;
				else g_d = G_ERR;
			end
			G_EXPD: begin
				if (c_dig) g_d = G_EXPD;
				else if (c_sp) g_d = G_TRAIL;
				else g_d = G_ERR;
			end
			G_TRAIL: begin
				if (c_sp) g_d = G_TRAIL;
				else g_d = G_ERR;
			end
			default: g_d = G_ERR;
		endcase
	end

	always_comb begin
		mant_dig = c_dig && (g_q == G_WS || g_q == G_SGN || g_q == G_INT || g_q == G_FRAC);
		exp_dig  = c_dig && (g_q == G_EXP0 || g_q == G_EXPS || g_q == G_EXPD);
		in_frac  = g_q == G_FRAC;
		ex10     = {1'b0, ex_q, 3'b000} + {3'b000, ex_q, 1'b0} + {17'd0, dval};
		ex_n     = (ex10 > 21'(EXP_CAP)) ? 17'(EXP_CAP) : ex10[16:0];
		gram_ok  = g_q == G_INT || g_q == G_EXPD || g_q == G_TRAIL || (g_q == G_FRAC && any_q);
		pf       = eneg_q ? p_q - $signed({2'b00, ex_q}) : p_q + $signed({2'b00, ex_q});
		zneg     = PF_ZERO - pf;
		ev_stop  = stop_ok_q && idx_q == STOP_CNT;
		ev_zero  = gram_ok && (!started_q || (!neg_q && pf <= PF_ZERO && zneg >= Z_BIG));
		ev_one   = gram_ok && started_q && !neg_q && pf == PF_ONE && first_q == 4'd1 && !rest_q;
		ev_conv  = gram_ok && started_q && !neg_q && pf <= PF_ZERO && zneg < Z_BIG;
		align_cnt = FL - nsig_q - zneg[5:0];
		dv       = {frac_q[FRAC_DIGITS-1], 1'b0} + {4'd0, carry_q};
		cn       = dv >= 5'd10;
		nd       = cn ? 4'(dv - 5'd10) : dv[3:0];
		acc_fin  = {acc_q[14:0], cn};
		store_ch = st_q == P_IDLE && start && !op_eol && !disc_q && cnt_q < FULL_CNT;
	end

	always_comb begin
		unique case (st_q)
			P_IDLE: begin
				if (start && op_eol && !disc_q && cnt_q != '0) st_d = P_RD;
				else if (start) st_d = P_DONE;
				else st_d = P_IDLE;
			end
			P_RD:    st_d = (idx_q == cnt_q) ? P_EVAL : P_CH;
			P_CH:    st_d = c_nul ? P_EVAL : P_RD;
			P_EVAL:  st_d = (!ev_stop && ev_conv) ? P_ALIGN : P_DONE;
			P_ALIGN: st_d = (aux_q == 6'd1) ? P_DBL : P_ALIGN;
			P_DBL:   st_d = (aux_q == FL - 6'd1 && pass_q == 4'd15) ? P_DONE : P_DBL;
			P_DONE:  st_d = P_IDLE;
			default: st_d = P_IDLE;
		endcase
	end

	always_comb begin
		done      = st_q == P_DONE;
		res.stop  = stop_q;
		res.set   = set_q;
		res.level = level_q;
	end

	always_ff @(posedge clk) begin
		if (store_ch) begin
			line_mem[cnt_q[AW-1:0]] <= ch;
		end
		rd_q <= line_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= P_IDLE;
			cnt_q  <= '0;
			disc_q <= 1'b0;
			eol_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == P_IDLE && start) begin
				eol_q <= op_eol;
				if (op_eol) begin
					disc_q <= 1'b0;
				end else if (!disc_q) begin
					if (cnt_q < FULL_CNT) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						cnt_q  <= '0;
						disc_q <= 1'b1;
					end
				end
			end
			if (st_q == P_DONE && eol_q) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			P_IDLE: begin
				if (start) begin
					stop_q    <= 1'b0;
					set_q     <= 1'b0;
					idx_q     <= '0;
					g_q       <= G_WS;
					any_q     <= 1'b0;
					started_q <= 1'b0;
					rest_q    <= 1'b0;
					neg_q     <= 1'b0;
					eneg_q    <= 1'b0;
					stop_ok_q <= 1'b1;
					first_q   <= '0;
					nsig_q    <= '0;
					p_q       <= '0;
					ex_q      <= '0;
					for (int k = 0; k < FRAC_DIGITS; k++) frac_q[k] <= '0;
				end
			end
			P_CH: begin
				if (!c_nul) begin
					idx_q <= idx_q + CW'(1);
					g_q   <= g_d;
					if (idx_q >= STOP_CNT || !c_stop) stop_ok_q <= 1'b0;
					if (g_q == G_WS && c_sign) neg_q <= rd_q == CH_MINUS;
					if (g_q == G_EXP0 && c_sign) eneg_q <= rd_q == CH_MINUS;
					if (exp_dig) ex_q <= ex_n;
					if (mant_dig) begin
						any_q <= 1'b1;
						if (started_q || dval != 4'd0) begin
							if (started_q && dval != 4'd0) rest_q <= 1'b1;
							if (!started_q) first_q <= dval;
							started_q <= 1'b1;
							if (nsig_q < 6'(SIG_DIGITS)) begin
								nsig_q <= nsig_q + 6'd1;
								for (int k = 0; k < FRAC_DIGITS - 1; k++) begin
									frac_q[k] <= frac_q[k+1];
								end
								frac_q[FRAC_DIGITS-1] <= dval;
							end
							if (!in_frac) p_q <= p_q + PF_ONE;
						end else if (in_frac) begin
							p_q <= p_q - PF_ONE;
						end
					end
				end
			end
			P_EVAL: begin
				if (ev_stop) begin
					stop_q <= 1'b1;
				end else if (ev_zero) begin
					set_q   <= 1'b1;
					level_q <= '0;
				end else if (ev_one) begin
					set_q   <= 1'b1;
					level_q <= Q_ONE;
				end else if (ev_conv) begin
					aux_q <= align_cnt;
				end
			end
			P_ALIGN: begin
				for (int k = 0; k < FRAC_DIGITS - 1; k++) frac_q[k] <= frac_q[k+1];
				frac_q[FRAC_DIGITS-1] <= '0;
				aux_q <= aux_q - 6'd1;
				if (aux_q == 6'd1) begin
					aux_q   <= '0;
					pass_q  <= '0;
					carry_q <= 1'b0;
					acc_q   <= '0;
				end
			end
			P_DBL: begin
				frac_q[0] <= nd;
				for (int k = 1; k < FRAC_DIGITS; k++) frac_q[k] <= frac_q[k-1];
				if (aux_q == FL - 6'd1) begin
					aux_q   <= '0;
					carry_q <= 1'b0;
					acc_q   <= acc_fin;
					pass_q  <= pass_q + 4'd1;
					if (pass_q == 4'd15) begin
						set_q   <= 1'b1;
						level_q <= 16'((17'(acc_fin) + 17'd1) >> 1);
					end
				end else begin
					aux_q   <= aux_q + 6'd1;
					carry_q <= cn;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lclp_tick.sv -----
// Tick unit: over-current check, proportional drive and normalised position feedback.
`default_nettype none

module lclp_tick (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lclp_pkg::tick_req_t  req,
	input  lclp_pkg::cfg_t       cfg,
	output logic                 done,
	output lclp_pkg::tick_resp_t resp
);
	import lclp_pkg::*;

	tick_state_t st_q, st_d;
	tick_req_t req_q;
	logic trip_q, run_q, eneg_q, fzero_q, ffull_q;
	logic [31:0] prod_q;
	logic [16:0] eabs_q;
	logic [32:0] mag_q;
	logic [7:0] duty_q;
	logic [1:0] dir_q;
	logic [16:0] rem_q;
	logic [15:0] num_q, quo_q;
	logic [3:0] bit_q;

	logic [16:0] target;
	logic signed [17:0] err;
	logic [24:0] shifted;
	logic [7:0] duty_n;
	logic [17:0] trial, dd;
	logic ge;

	always_comb begin
		target  = 17'((33'(prod_q) + 33'd16384) >> 15);
		err     = $signed({1'b0, target}) - $signed({{2{req_q.position[15]}}, req_q.position});
		shifted = mag_q[32:8];
		duty_n  = (shifted > {17'd0, cfg.dlim}) ? cfg.dlim : shifted[7:0];
		trial   = {rem_q, num_q[15]};
		dd      = {1'b0, cfg.travel, 1'b0};
		ge      = trial >= dd;
	end

	always_comb begin
		unique case (st_q)
			T_IDLE:  st_d = start ? T_MUL : T_IDLE;
			T_MUL:   st_d = T_ERR;
			T_ERR:   st_d = T_SCALE;
			T_SCALE: st_d = T_SAT;
			T_SAT:   st_d = T_DIV;
			T_DIV:   st_d = (bit_q == 4'd15) ? T_DONE : T_DIV;
			T_DONE:  st_d = T_IDLE;
			default: st_d = T_IDLE;
		endcase
	end

	always_comb begin
		done      = st_q == T_DONE;
		resp.trip = trip_q;
		resp.dir  = dir_q;
		resp.duty = duty_q;
		if (fzero_q) resp.fpos = '0;
		else if (ffull_q) resp.fpos = Q_ONE;
		else resp.fpos = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			T_IDLE: begin
				if (start) begin
					req_q   <= req;
					trip_q  <= req.active && req.current_ma >= cfg.ilim;
					run_q   <= req.active && req.current_ma < cfg.ilim;
					fzero_q <= req.position <= $signed(16'd0);
					ffull_q <= $unsigned(req.position) >= cfg.travel;
					rem_q   <= {1'b0, req.position};
					num_q   <= cfg.travel;
					quo_q   <= '0;
					bit_q   <= '0;
				end
			end
			T_MUL: prod_q <= req_q.setpoint * cfg.travel;
			T_ERR: begin
				eneg_q <= err[17];
				eabs_q <= err[17] ? 17'(-err) : err[16:0];
			end
			T_SCALE: mag_q <= eabs_q * cfg.kp;
			T_SAT: begin
				if (!run_q || duty_n == 8'd0) begin
					duty_q <= run_q ? duty_n : 8'd0;
					dir_q  <= DIR_STOP;
				end else begin
					duty_q <= duty_n;
					dir_q  <= eneg_q ? DIR_REV : DIR_FWD;
				end
			end
			T_DIV: begin
				rem_q <= ge ? 17'(trial - dd) : trial[16:0];
				quo_q <= {quo_q[14:0], ge};
				num_q <= {num_q[14:0], 1'b0};
				bit_q <= bit_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/line_commanded_position_loop.sv -----
// Top level: front end, line interpreter, tick unit, loop state and result queue.
//
// Input beats (serial bytes or control ticks) enter a four-deep queue and are
// carried out in order by the back end. A plain byte is handed to the line store,
// and a tick runs two multiplies and a 16-step position divider. A line end scans
// the stored characters with a read and a check step for each, and a number line
// then runs alignment shifts and 16 doubling passes over the 46 digits of the
// digit-serial decimal register.
// A tick gives one or two result beats into a four-deep result queue and
// waits until two places are free there.
`default_nettype none

module line_commanded_position_loop #(
	parameter int unsigned LINE_CHARS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lclp_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output lclp_pkg::out_item_t result,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [15:0]         wr_data
);
	import lclp_pkg::*;

	localparam int unsigned OPW = $clog2(OQ_DEPTH);
	localparam int unsigned OCW = $clog2(OQ_DEPTH + 1);

	logic q_valid, deq, p_start, t_start, p_done, t_done, room;
	queue_entry_t q_head;
	line_res_t lres;
	tick_req_t treq;
	tick_resp_t tresp;
	cfg_t cfg;
	back_state_t st_q, st_d;

	logic [15:0] kp_q, ilim_q, travel_q, setpoint_q;
	logic [7:0] fbt_q, dlim_q, tc_q, tc1;
	logic motion_q, fault_q, fb, on_n, fault_n;

	out_item_t oq_q [OQ_DEPTH];
	logic [OPW-1:0] oq_wp_q, oq_rp_q;
	logic [OCW-1:0] oq_cnt_q;
	out_item_t drv, fbk;
	logic popped;

	lclp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.deq     (deq),
		.q_valid (q_valid),
		.q_head  (q_head)
	);

	lclp_parse #(.LINE_CHARS(LINE_CHARS)) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (p_start),
		.op_eol (q_head.op == OP_EOL),
		.ch     (q_head.rx_byte),
		.done   (p_done),
		.res    (lres)
	);

	lclp_tick u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (t_start),
		.req    (treq),
		.cfg    (cfg),
		.done   (t_done),
		.resp   (tresp)
	);

	always_comb begin
		cfg.kp      = kp_q;
		cfg.ilim    = ilim_q;
		cfg.travel  = travel_q;
		cfg.fbticks = fbt_q;
		cfg.dlim    = dlim_q;
		treq.active     = motion_q && !fault_q;
		treq.position   = q_head.position;
		treq.current_ma = q_head.current_ma;
		treq.setpoint   = setpoint_q;
		room = oq_cnt_q <= OCW'(OQ_DEPTH - 2);
	end

	always_comb begin
		unique case (st_q)
			B_IDLE: begin
				if (q_valid && q_head.op != OP_TICK) st_d = B_LINE;
				else if (q_valid && room) st_d = B_TICK;
				else st_d = B_IDLE;
			end
			B_LINE:  st_d = p_done ? B_IDLE : B_LINE;
			B_TICK:  st_d = t_done ? B_IDLE : B_TICK;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		deq     = st_q == B_IDLE && q_valid && (q_head.op != OP_TICK || room);
		p_start = deq && q_head.op != OP_TICK;
		t_start = deq && q_head.op == OP_TICK;
	end

	always_comb begin
		tc1     = tc_q + 8'd1;
		fb      = tc1 >= fbt_q;
		on_n    = motion_q && !tresp.trip;
		fault_n = fault_q || tresp.trip;
		drv.kind         = KIND_DRIVE;
		drv.drive_dir    = tresp.dir;
		drv.drive_duty   = tresp.duty;
		drv.driver_on    = on_n;
		drv.fault        = fault_n;
		drv.feedback_pos = '0;
		drv.last         = !fb;
		fbk.kind         = KIND_FEEDBACK;
		fbk.drive_dir    = DIR_STOP;
		fbk.drive_duty   = '0;
		fbk.driver_on    = on_n;
		fbk.fault        = fault_n;
		fbk.feedback_pos = tresp.fpos;
		fbk.last         = 1'b1;
		empty  = oq_cnt_q == '0;
		result = oq_q[oq_rp_q];
		popped = pop && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			kp_q       <= 16'd1280;
			ilim_q     <= 16'd4500;
			travel_q   <= 16'd4825;
			fbt_q      <= 8'd3;
			dlim_q     <= 8'd255;
			setpoint_q <= '0;
			motion_q   <= 1'b0;
			fault_q    <= 1'b0;
			tc_q       <= '0;
			oq_wp_q    <= '0;
			oq_rp_q    <= '0;
			oq_cnt_q   <= '0;
		end else begin
			st_q <= st_d;
			if (wr_en) begin
				case (wr_index)
					REG_KP:      kp_q     <= wr_data;
					REG_ILIM:    ilim_q   <= wr_data;
					REG_TRAVEL:  travel_q <= wr_data;
					REG_FBTICKS: fbt_q    <= wr_data[7:0];
					REG_DLIM:    dlim_q   <= wr_data[7:0];
					default: begin
					end
				endcase
			end
			if (st_q == B_LINE && p_done) begin
				if (lres.stop) begin
					motion_q <= 1'b0;
				end else if (lres.set && !fault_q) begin
					setpoint_q <= lres.level;
					motion_q   <= 1'b1;
				end
			end
			if (st_q == B_TICK && t_done) begin
				motion_q <= on_n;
				fault_q  <= fault_n;
				tc_q     <= fb ? 8'd0 : tc1;
				oq_wp_q  <= oq_wp_q + (fb ? OPW'(2) : OPW'(1));
			end
			if (popped) begin
				oq_rp_q <= oq_rp_q + OPW'(1);
			end
			oq_cnt_q <= oq_cnt_q
				+ ((st_q == B_TICK && t_done) ? (fb ? OCW'(2) : OCW'(1)) : OCW'(0))
				- OCW'(popped);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_TICK && t_done) begin
			oq_q[oq_wp_q] <= drv;
			if (fb) begin
				oq_q[oq_wp_q + OPW'(1)] <= fbk;
			end
		end
	end

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("over-current fault cleared after latching");

	a_no_enable_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(motion_q) |-> !$past(fault_q))
		else $error("drive enabled while the fault was latched");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OCW'(OQ_DEPTH))
		else $error("result queue overfilled");

	a_tick_room: assert property (@(posedge clk) disable iff (!arst_n)
		t_start |-> oq_cnt_q <= OCW'(OQ_DEPTH - 2))
		else $error("tick started without room for its results");

endmodule

`default_nettype wire
